>>> rtl/core/gcb_pkg.sv
// Shared types and constants of the grey contrast binarise unit.
// Depends on nothing; the front end, divider, back end and top level import it.
`default_nettype none

package gcb_pkg;

    // Field widths
    localparam int LEVEL_W    = 8;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Divider geometry: level*255 over an 8-bit level
    localparam int DIVD_W = 2 * LEVEL_W;
    localparam int DIVS_W = LEVEL_W;

    // Queue depths
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THR_DIV    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPREAD = 1'd1;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] THR_DIV_RST    = 8'd2;
    localparam logic [CFG_DATA_W-1:0] MIN_SPREAD_RST = 8'd32;

    // Request codes on the input word
    localparam logic [REQ_W-1:0] REQ_SCAN  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_COUNT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MAP   = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [LEVEL_W-1:0] grey_level;
        logic               last_pixel;
    } t_in_word;

    typedef struct packed {
        logic [LEVEL_W-1:0] out_level;
        logic               out_last;
    } t_out_word;

    // Classified command between front and back end
    typedef enum logic [1:0] {
        CLS_SCAN,
        CLS_COUNT,
        CLS_MAP
    } t_cls;

    typedef struct packed {
        t_cls               cls;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } t_cmd;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> rtl/core/gcb_fifo.sv
// Small register queue of generic width, used for commands and results.
// Depends on nothing.
`default_nettype none

module gcb_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    input  wire logic         i_rd,
    output logic [W-1:0]      o_rdata,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_ok;
    logic          rd_ok;
    logic [AW-1:0] n_wp;
    logic [AW-1:0] n_rp;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    // pointer wrap
    assign n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= n_wp;
            end
            if (rd_ok) begin
                r_rp <= n_rp;
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gcb_front.sv
// Front end: takes input words and classifies them into back-end commands.
// Depends on gcb_pkg.
`default_nettype none

module gcb_front (
    input  wire logic             i_push,
    input  wire gcb_pkg::t_in_word i_in_word,
    input  wire logic             i_cmd_full,
    output logic                  o_cmd_wr,
    output gcb_pkg::t_cmd         o_cmd
);

    import gcb_pkg::*;

    logic known;

    // decode the request; an unknown request is taken and dropped
    always_comb begin
        known       = 1'b1;
        o_cmd.cls   = CLS_SCAN;
        o_cmd.level = i_in_word.grey_level;
        o_cmd.last  = i_in_word.last_pixel;
        case (i_in_word.req_type)
            REQ_SCAN:  o_cmd.cls = CLS_SCAN;
            REQ_COUNT: o_cmd.cls = CLS_COUNT;
            REQ_MAP:   o_cmd.cls = CLS_MAP;
            default:   known     = 1'b0;
        endcase
    end

    assign o_cmd_wr = i_push && !i_cmd_full && known;

endmodule

`default_nettype wire

>>> rtl/core/gcb_div.sv
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on gcb_pkg.
`default_nettype none

module gcb_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gcb_pkg::t_div_req i_req,
    output gcb_pkg::t_div_rsp      o_rsp
);

    import gcb_pkg::*;

    localparam int SW = $clog2(DIVD_W);

    logic              r_busy;
    logic              r_done;
    logic [SW-1:0]     r_step;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_dvs;
    logic [DIVS_W:0]   rem_sh;
    logic              ge;
    logic [DIVS_W-1:0] n_rem;
    logic [DIVD_W-1:0] n_quo;

    // one shift-subtract step
    always_comb begin
        rem_sh = {r_rem, r_quo[DIVD_W-1]};
        ge     = (rem_sh >= {1'b0, r_dvs});
        n_rem  = ge ? DIVS_W'(rem_sh - {1'b0, r_dvs}) : DIVS_W'(rem_sh);
        n_quo  = {r_quo[DIVD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quo  <= n_quo;
                r_step <= r_step + 1'b1;
                if (r_step == SW'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

>>> rtl/core/gcb_back.sv
// Back end: image statistics, threshold decision and pixel mapping.
// Depends on gcb_pkg; drives the shared divider and the result queue.
`default_nettype none

module gcb_back #(
    parameter int MAX_PIXELS = 4194304
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [gcb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gcb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                      i_cmd_valid,
    input  wire gcb_pkg::t_cmd             i_cmd,
    output logic                           o_cmd_pop,
    input  wire logic                      i_res_full,
    output logic                           o_res_push,
    output gcb_pkg::t_out_word             o_res_word,
    output gcb_pkg::t_div_req              o_div_req,
    input  wire gcb_pkg::t_div_rsp         i_div_rsp
);

    import gcb_pkg::*;

    localparam int CNT_W = $clog2(MAX_PIXELS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_CUT_DIV,
        S_MAP_DIV,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [CFG_DATA_W-1:0] r_thr_div;
    logic [CFG_DATA_W-1:0] r_min_spread;
    logic [LEVEL_W-1:0]   r_run_max;
    logic [LEVEL_W-1:0]   r_run_min;
    logic [CNT_W-1:0]     r_pix_cnt;
    logic [CNT_W-1:0]     r_brt_cnt;
    logic                 r_invert;
    logic [LEVEL_W-1:0]   r_high;
    logic [LEVEL_W-1:0]   r_low;
    logic [LEVEL_W-1:0]   r_cut;
    logic                 r_pass;
    logic [LEVEL_W-1:0]   r_q;
    logic                 r_last;

    logic signed [9:0]    mid_d;
    logic signed [9:0]    mid_h;
    logic signed [9:0]    mid_m;
    logic [LEVEL_W-1:0]   mid;
    logic                 dec_inv;
    logic [LEVEL_W-1:0]   dec_hi;
    logic [LEVEL_W-1:0]   dec_lo;
    logic signed [9:0]    spread;
    logic                 spread_lt;
    logic [LEVEL_W-1:0]   map_r;
    logic                 map_thru;
    logic                 map_direct;
    logic [LEVEL_W-1:0]   map_direct_q;
    logic [LEVEL_W-1:0]   div_sat;
    logic [LEVEL_W-1:0]   div_q;
    logic                 clr_stats;

    // midpoint of the running range, halved toward zero
    always_comb begin
        mid_d = $signed({2'b00, r_run_max}) - $signed({2'b00, r_run_min});
        mid_h = (mid_d + $signed({9'd0, mid_d[9]})) >>> 1;
        mid_m = mid_h + $signed({2'b00, r_run_min});
        mid   = mid_m[LEVEL_W-1:0];
    end

    // decision terms from the finished counts
    always_comb begin
        dec_inv   = ({r_brt_cnt, 1'b0} > {1'b0, r_pix_cnt});
        dec_hi    = dec_inv ? ~r_run_min : r_run_max;
        dec_lo    = dec_inv ? ~r_run_max : r_run_min;
        spread    = $signed({2'b00, dec_hi}) - $signed({2'b00, dec_lo});
        spread_lt = (spread < $signed({2'b00, r_min_spread}));
    end

    // pixel mapping without a divide
    always_comb begin
        map_r        = i_cmd.level ^ {LEVEL_W{r_invert}};
        map_thru     = r_pass || (r_high == '0);
        map_direct   = map_thru || (map_r <= r_cut);
        map_direct_q = map_thru ? map_r : '0;
    end

    // stretched level from the divider, saturated, low levels forced white
    always_comb begin
        div_sat = (|i_div_rsp.quotient[DIVD_W-1:LEVEL_W]) ? '1
                                                          : i_div_rsp.quotient[LEVEL_W-1:0];
        div_q   = (div_sat <= r_low) ? '1 : div_sat;
    end

    // command pop, result push and divider start
    always_comb begin
        o_cmd_pop          = 1'b0;
        o_res_push         = 1'b0;
        o_res_word         = '{out_level: r_q, out_last: r_last};
        o_div_req.start    = 1'b0;
        o_div_req.dividend = {map_r, LEVEL_W'(0)} - {LEVEL_W'(0), map_r};
        o_div_req.divisor  = r_high;
        case (r_state)
            S_IDLE: begin
                o_cmd_pop = i_cmd_valid && ((i_cmd.cls != CLS_MAP) || !i_res_full);
                if (o_cmd_pop && (i_cmd.cls == CLS_MAP)) begin
                    o_res_push      = map_direct;
                    o_res_word      = '{out_level: map_direct_q, out_last: i_cmd.last};
                    o_div_req.start = !map_direct;
                end
            end
            S_DECIDE: begin
                o_div_req.start    = dec_inv && !spread_lt;
                o_div_req.dividend = {LEVEL_W'(0), spread[LEVEL_W-1:0]};
                o_div_req.divisor  = (r_thr_div == '0) ? DIVS_W'(1) : r_thr_div;
            end
            S_EMIT: begin
                o_res_push = !i_res_full;
            end
            default: ;
        endcase
        clr_stats = o_res_push && o_res_word.out_last;
    end

    // state, configuration and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_thr_div    <= THR_DIV_RST;
            r_min_spread <= MIN_SPREAD_RST;
            r_run_max    <= '0;
            r_run_min    <= '1;
            r_pix_cnt    <= '0;
            r_brt_cnt    <= '0;
            r_invert     <= 1'b0;
            r_high       <= '0;
            r_low        <= '0;
            r_cut        <= '0;
            r_pass       <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THR_DIV:    r_thr_div    <= i_cfg_data;
                    CFG_MIN_SPREAD: r_min_spread <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_last <= i_cmd.last;
                        case (i_cmd.cls)
                            CLS_SCAN: begin
                                if (i_cmd.level > r_run_max) begin
                                    r_run_max <= i_cmd.level;
                                end
                                if (i_cmd.level < r_run_min) begin
                                    r_run_min <= i_cmd.level;
                                end
                            end
                            CLS_COUNT: begin
                                if (r_pix_cnt < CNT_W'(MAX_PIXELS)) begin
                                    r_pix_cnt <= r_pix_cnt + 1'b1;
                                end
                                if ((i_cmd.level > mid) &&
                                    (r_brt_cnt < CNT_W'(MAX_PIXELS))) begin
                                    r_brt_cnt <= r_brt_cnt + 1'b1;
                                end
                                if (i_cmd.last) begin
                                    r_state <= S_DECIDE;
                                end
                            end
                            CLS_MAP: begin
                                if (!map_direct) begin
                                    r_state <= S_MAP_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DECIDE: begin
                    r_invert <= dec_inv;
                    r_high   <= dec_hi;
                    r_low    <= dec_lo;
                    r_pass   <= (dec_hi == '0);
                    if (spread_lt) begin
                        r_cut   <= '1;
                        r_state <= S_IDLE;
                    end else if (dec_inv) begin
                        r_state <= S_CUT_DIV;
                    end else begin
                        r_cut   <= mid;
                        r_state <= S_IDLE;
                    end
                end
                S_CUT_DIV: begin
                    if (i_div_rsp.done) begin
                        r_cut   <= i_div_rsp.quotient[LEVEL_W-1:0] + r_low;
                        r_state <= S_IDLE;
                    end
                end
                S_MAP_DIV: begin
                    if (i_div_rsp.done) begin
                        r_q     <= div_q;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (o_res_push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // end of image: statistics back to their start values
            if (clr_stats) begin
                r_run_max <= '0;
                r_run_min <= '1;
                r_pix_cnt <= '0;
                r_brt_cnt <= '0;
                r_invert  <= 1'b0;
                r_high    <= '0;
                r_low     <= '0;
                r_cut     <= '0;
                r_pass    <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/grey_contrast_binarize_unit.sv
// Top level of the grey contrast binarise unit: front end, command queue,
// back end, shared divider and result queue. Depends on gcb_pkg.
//
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+------------------------------
//  input    | in        | push / full          | i_in_word  (t_in_word)
//  result   | out       | pop / empty          | o_out_word (t_out_word)
//  config   | in        | i_cfg_we, i_cfg_idx  | i_cfg_data (8 bits)
//
// Words are taken at one per cycle until the 4-deep command queue fills.
// A range-scan or count pixel, and a map pixel that needs no stretch, is
// handled directly; a stretched map pixel waits on the 16-step divider.
// The last count pixel adds a decision step, and a cut level divide if the
// image is inverted and the spread reaches the minimum. Reset is synchronous
// and clears both queues and the statistics; the result queue stalls the
// back end only when both of its entries wait to be popped.
`default_nettype none

module grey_contrast_binarize_unit #(
    parameter int MAX_PIXELS = 4194304
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [gcb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gcb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                      push,
    output logic                           full,
    input  wire gcb_pkg::t_in_word         i_in_word,
    input  wire logic                      pop,
    output logic                           empty,
    output gcb_pkg::t_out_word             o_out_word
);

    import gcb_pkg::*;

    logic      cmd_wr;
    t_cmd      cmd_in;
    logic      cmd_empty;
    logic      cmd_pop;
    logic [$bits(t_cmd)-1:0]      cmd_bits;
    logic      res_full;
    logic      res_push;
    t_out_word res_word;
    logic [$bits(t_out_word)-1:0] res_bits;
    t_div_req  div_req;
    t_div_rsp  div_rsp;

    // classify incoming words
    gcb_front u_front (
        .i_push     (push),
        .i_in_word  (i_in_word),
        .i_cmd_full (full),
        .o_cmd_wr   (cmd_wr),
        .o_cmd      (cmd_in)
    );

    // command queue between front and back end
    gcb_fifo #(
        .W     ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_wdata (cmd_in),
        .o_full  (full),
        .i_rd    (cmd_pop),
        .o_rdata (cmd_bits),
        .o_empty (cmd_empty)
    );

    // statistics, decision and mapping
    gcb_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (t_cmd'(cmd_bits)),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res_word  (res_word),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    // shared divider
    gcb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // result queue
    gcb_fifo #(
        .W     ($bits(t_out_word)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res_word),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (res_bits),
        .o_empty (empty)
    );

    assign o_out_word = t_out_word'(res_bits);

    // no result is pushed into a full result queue
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    // commands are only taken from a non-empty queue
    a_cmd_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");

    // the divider is never restarted while it works
    a_div_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // a divide and a direct result never coincide
    a_push_or_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_push && div_req.start))
        else $error("result pushed while a divide starts");

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule

`default_nettype wire
